>>> rtl/svalloc_pkg.sv
// ----------------------------------------------------------------------------
// svalloc_pkg: shared types and codes for the voice allocator
// Request and action codes, per-cell control bundle and chain link types.
// ----------------------------------------------------------------------------
package svalloc_pkg;

  localparam int unsigned NoteW  = 7;
  localparam int unsigned FvW    = 3;
  localparam int unsigned FvSpan = 8;

  typedef enum logic [1:0] {
    REQ_NOTE_ON  = 2'd0,
    REQ_NOTE_OFF = 2'd1,
    REQ_FINISHED = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_NONE    = 2'd2,
    ACT_FREE    = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } state_e;

  // broadcast to every cell
  typedef struct packed {
    logic             en;
    logic             on;
    logic             off;
    logic             fin;
    logic             poly;
    logic             any_free;
    logic             any_unheld;
    logic [NoteW-1:0] note;
    logic [FvW-1:0]   fv;
  } cell_ctrl_t;

  // prefix flags from lower cells
  typedef struct packed {
    logic free;
    logic unheld;
    logic match;
  } scan_t;

  // result gathered along the row
  typedef struct packed {
    logic             hit;
    logic             stolen;
    logic [FvW-1:0]   idx;
    logic [NoteW-1:0] note;
  } acc_t;

endpackage

>>> rtl/svalloc_cell.sv
// ----------------------------------------------------------------------------
// svalloc_cell: one voice slot
// Holds active/held flags and the note of one voice, takes part in the
// lowest-index priority scan and merges its grant into the result chain.
// ----------------------------------------------------------------------------
module svalloc_cell
  import svalloc_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  scan_t      scan_i,
  output scan_t      scan_o,
  input  acc_t       acc_i,
  output acc_t       acc_o
);

  localparam logic [FvW-1:0] IdxBits = FvW'(IDX % FvSpan);
  localparam bit             FvOk    = (IDX < FvSpan);
  localparam bit             IsFirst = (IDX == 0);

  logic             active_q, active_d;
  logic             held_q, held_d;
  logic [NoteW-1:0] note_q;

  logic is_free, is_unheld, is_match;
  logic start_sel, fin_sel, grant;

  always_comb begin
    is_free   = !active_q;
    is_unheld = !held_q;
    is_match  = active_q && held_q && (note_q == ctrl_i.note);

    scan_o.free   = scan_i.free | is_free;
    scan_o.unheld = scan_i.unheld | is_unheld;
    scan_o.match  = scan_i.match | is_match;

    if (!ctrl_i.poly) begin
      start_sel = IsFirst;
    end else if (ctrl_i.any_free) begin
      start_sel = is_free && !scan_i.free;
    end else if (ctrl_i.any_unheld) begin
      start_sel = is_unheld && !scan_i.unheld;
    end else begin
      start_sel = IsFirst;
    end

    fin_sel = FvOk && (ctrl_i.fv == IdxBits) && active_q;

    grant = ctrl_i.en && ((ctrl_i.on && start_sel) ||
                          (ctrl_i.off && is_match && !scan_i.match) ||
                          (ctrl_i.fin && fin_sel));

    acc_o.hit    = acc_i.hit | grant;
    acc_o.stolen = acc_i.stolen | (grant & active_q);
    acc_o.idx    = acc_i.idx | (grant ? IdxBits : '0);
    acc_o.note   = acc_i.note | (grant ? note_q : '0);

    active_d = active_q;
    held_d   = held_q;
    if (grant) begin
      if (ctrl_i.on) begin
        active_d = 1'b1;
        held_d   = 1'b1;
      end else if (ctrl_i.off) begin
        held_d = 1'b0;
      end else begin
        active_d = 1'b0;
        held_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      held_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      held_q   <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (grant && ctrl_i.on) begin
      note_q <= ctrl_i.note;
    end
  end

endmodule

>>> rtl/synth_voice_allocator.sv
// ----------------------------------------------------------------------------
// synth_voice_allocator: polyphonic voice allocation with stealing
// Row of voice cells; note-on/off and voice-finished events in, one result
// per event out.
//
//   channel  dir  handshake                 payload
//   in       in   in_valid_i / in_stall_o   req_type_i, note_i, finished_voice_i
//   out      out  out_valid_o / out_stall_i action_o, voice_index_o, out_note_o,
//                                           stolen_o
//   cfg      in   cfg_valid_i / cfg_ready_o cfg_poly_mode_i
//
// Each event is first captured (with the row's any-free and any-released
// flags), then evaluated: the priority scan ripples through the row of
// NUM_VOICES cells and all cells update.
// Reset clears all voice flags and sets poly mode; no clearing pass.
// Input stalls during evaluation and while an unread result is stalled.
// cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module synth_voice_allocator
  import svalloc_pkg::*;
#(
  parameter int unsigned NUM_VOICES = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       req_type_i,
  input  logic [NoteW-1:0] note_i,
  input  logic [FvW-1:0]   finished_voice_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       action_o,
  output logic [FvW-1:0]   voice_index_o,
  output logic [NoteW-1:0] out_note_o,
  output logic             stolen_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_poly_mode_i
);

  state_e           state_q, state_d;
  logic             poly_q;
  logic [1:0]       req_type_q;
  logic [NoteW-1:0] note_q;
  logic [FvW-1:0]   fv_q;
  logic             any_free_q;
  logic             any_unheld_q;

  logic             out_valid_q, out_valid_d;
  act_e             action_q, action_d;
  logic [FvW-1:0]   vidx_q, vidx_d;
  logic [NoteW-1:0] onote_q, onote_d;
  logic             stolen_q, stolen_d;

  logic       in_xfer;
  cell_ctrl_t ctrl;
  scan_t      scan [NUM_VOICES+1];
  acc_t       acc [NUM_VOICES+1];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_xfer     = in_valid_i && !in_stall_o;

  assign scan[0] = '0;
  assign acc[0]  = '0;

  always_comb begin
    ctrl.en         = (state_q == ST_EVAL);
    ctrl.on         = (req_type_q == REQ_NOTE_ON);
    ctrl.off        = (req_type_q == REQ_NOTE_OFF);
    ctrl.fin        = (req_type_q == REQ_FINISHED);
    ctrl.poly       = poly_q;
    ctrl.any_free   = any_free_q;
    ctrl.any_unheld = any_unheld_q;
    ctrl.note       = note_q;
    ctrl.fv         = fv_q;
  end

  for (genvar g = 0; g < NUM_VOICES; g++) begin : g_cell
    svalloc_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(ctrl),
      .scan_i(scan[g]),
      .scan_o(scan[g+1]),
      .acc_i (acc[g]),
      .acc_o (acc[g+1])
    );
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    action_d    = action_q;
    vidx_d      = vidx_q;
    onote_d     = onote_q;
    stolen_d    = stolen_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
        action_d    = ACT_NONE;
        vidx_d      = '0;
        onote_d     = '0;
        stolen_d    = 1'b0;
        if (acc[NUM_VOICES].hit) begin
          vidx_d = acc[NUM_VOICES].idx;
          if (ctrl.on) begin
            action_d = ACT_START;
            onote_d  = note_q;
            stolen_d = acc[NUM_VOICES].stolen;
          end else if (ctrl.off) begin
            action_d = ACT_RELEASE;
            onote_d  = note_q;
          end else begin
            action_d = ACT_FREE;
            onote_d  = acc[NUM_VOICES].note;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      poly_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        poly_q <= cfg_poly_mode_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_type_q   <= req_type_i;
      note_q       <= note_i;
      fv_q         <= finished_voice_i;
      any_free_q   <= scan[NUM_VOICES].free;
      any_unheld_q <= scan[NUM_VOICES].unheld;
    end
    action_q <= action_d;
    vidx_q   <= vidx_d;
    onote_q  <= onote_d;
    stolen_q <= stolen_d;
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = action_q;
  assign voice_index_o = vidx_q;
  assign out_note_o    = onote_q;
  assign stolen_o      = stolen_q;

`ifndef SYNTHESIS
  a_accept_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_EVAL))
    else $error("accepted event did not enter evaluation");

  a_eval_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> !out_valid_q)
    else $error("evaluation while result register occupied");

  a_result_from_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_EVAL))
    else $error("result appeared without evaluation");

  a_start_always_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL && ctrl.on) |-> acc[NUM_VOICES].hit)
    else $error("note-on found no voice");
`endif

endmodule
